// ===== rtl/htw_pkg.sv =====
// ----------------------------------------------------------------------------
// htw_pkg: shared types and constants of the hashed timing wheel
// field structs, status and kind codes, defaults
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int TIMERS_DEF = 32;
  localparam int SLOTS_DEF  = 16;
  localparam int ROUNDS_W   = 28;
  localparam logic [15:0] TICK_PERIOD_RST = 16'd100;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [2:0] ST_FIRED     = 3'd0;
  localparam logic [2:0] ST_ADDED     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_TICK_DONE = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ident;
    logic [31:0] interval_ms;
    logic        periodic;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_ident;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

endpackage

// ===== rtl/htw_div.sv =====
// ----------------------------------------------------------------------------
// htw_div: iterative divider
// restoring radix-2 division of a 32-bit value by a 16-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module htw_div (
  input  logic              clk,
  input  logic              rst_n,
  input  htw_pkg::div_req_t req,
  output logic              busy,
  output logic              done,
  output logic [31:0]       quot
);
  import htw_pkg::*;

  logic [31:0] quot_r, quot_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0] trial;
  logic [16:0] diff;

  always_comb begin
    trial = {rem_r[15:0], quot_r[31]};
    diff = trial - {1'b0, dvs_r};
    quot_nxt = quot_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = (req.divisor == 16'd0) ? 16'd1 : req.divisor;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[16]) begin
        rem_nxt = diff;
        quot_nxt = {quot_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quot_nxt = {quot_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = quot_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without run");
  a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r && !$past(req.start))) else $error("divider done while busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != 6'd0)) else $error("divider count underflow");

endmodule

// ===== rtl/hashed_timing_wheel_unit.sv =====
// ----------------------------------------------------------------------------
// hashed_timing_wheel_unit: hashed timing wheel over a table of timers
// sequencer over a timer table, with a single bit-serial divider
// ----------------------------------------------------------------------------
// An add first runs the 32-step divider that turns the interval into ticks,
// then scans the table for a free entry, one entry a cycle, and loads its
// result. A cancel scans the table one entry a cycle until it finds the timer
// or reaches the last entry, then loads its result. A tick walks every entry
// once and then gives its tick done beat. Each result waits in an output
// register, and the walk pauses while it is held. The block takes one item
// at a time and is ready again once its last result beat has been taken.
module hashed_timing_wheel_unit #(
  parameter int TIMERS = htw_pkg::TIMERS_DEF,
  parameter int SLOTS  = htw_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  htw_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output htw_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import htw_pkg::*;

  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CW = $clog2(TIMERS + 1);
  localparam int SW = $clog2(SLOTS);
  localparam logic [31:0] SLOTS_32 = 32'(SLOTS);
  localparam logic [CW-1:0] LAST_IDX = CW'(TIMERS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RES  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] period_r;
  in_item_t    item_r;
  logic [31:0] ticks_r, ticks_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [SW-1:0] ptr_r, ptr_nxt;
  out_item_t   res_r, res_nxt;
  logic        res_v_r, res_v_nxt;

  logic [TIMERS-1:0] valid_r;
  logic [TIMERS-1:0] per_r;
  logic [31:0]       id_mem   [TIMERS];
  logic [SW-1:0]     slot_mem [TIMERS];
  logic [ROUNDS_W-1:0] rnd_mem [TIMERS];
  logic [31:0]       tk_mem   [TIMERS];

  logic        wr_en, set_valid, clr_valid, rnd_dec;
  logic [31:0] arm_ticks;
  logic [IW-1:0] ix;
  logic [ROUNDS_W-1:0] arm_rnd;
  logic [SW-1:0] arm_slot;
  logic [31:0] arm_r32;

  div_req_t    dreq;
  logic        dbusy, ddone;
  logic [31:0] dquot;

  htw_div u_div (
    .clk (clk), .rst_n (rst_n), .req (dreq),
    .busy (dbusy), .done (ddone), .quot (dquot)
  );

  assign ix = idx_r[IW-1:0];
  assign arm_r32 = arm_ticks / SLOTS_32;
  assign arm_rnd = (arm_r32 > 32'({ROUNDS_W{1'b1}})) ? {ROUNDS_W{1'b1}}
                 : arm_r32[ROUNDS_W-1:0];
  assign arm_slot = SW'((32'(ptr_r) + arm_ticks % SLOTS_32) % SLOTS_32);

  assign in_ready  = (state_r == S_IDLE) && !res_v_r;
  assign cfg_ready = 1'b1;
  assign out_valid = res_v_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt = state_r;
    ticks_nxt = ticks_r;
    idx_nxt = idx_r;
    ptr_nxt = ptr_r;
    res_nxt = res_r;
    res_v_nxt = res_v_r && !out_ready;
    dreq.start = 1'b0;
    dreq.dividend = item_r.interval_ms;
    dreq.divisor = period_r;
    wr_en = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    rnd_dec = 1'b0;
    arm_ticks = ticks_r;
    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_valid && in_ready) begin
          case (in_data.kind)
            KIND_ADD: begin
              state_nxt = S_DIV;
              dreq.start = 1'b1;
              dreq.dividend = in_data.interval_ms;
            end
            KIND_CANCEL: state_nxt = S_SCAN;
            KIND_TICK:   state_nxt = S_SCAN;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (ddone) begin
          ticks_nxt = (dquot == 32'd0) ? 32'd1 : dquot;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (item_r.kind == KIND_ADD) begin
          if (!valid_r[ix]) begin
            wr_en = 1'b1;
            set_valid = 1'b1;
            res_nxt = '{result_ident: item_r.ident, status: ST_ADDED, last: 1'b1};
            state_nxt = S_RES;
          end else if (idx_r == LAST_IDX) begin
            res_nxt = '{result_ident: item_r.ident, status: ST_FULL, last: 1'b1};
            state_nxt = S_RES;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (item_r.kind == KIND_CANCEL) begin
          if (valid_r[ix] && id_mem[ix] == item_r.ident) begin
            clr_valid = 1'b1;
            res_nxt = '{result_ident: item_r.ident, status: ST_CANCELLED, last: 1'b1};
            state_nxt = S_RES;
          end else if (idx_r == LAST_IDX) begin
            res_nxt = '{result_ident: item_r.ident, status: ST_NOT_FOUND, last: 1'b1};
            state_nxt = S_RES;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (!res_v_r || out_ready) begin
          if (valid_r[ix] && slot_mem[ix] == ptr_r) begin
            if (rnd_mem[ix] != '0) begin
              rnd_dec = 1'b1;
            end else begin
              res_nxt = '{result_ident: id_mem[ix], status: ST_FIRED, last: 1'b0};
              res_v_nxt = 1'b1;
              if (per_r[ix]) begin
                arm_ticks = tk_mem[ix];
                wr_en = 1'b1;
              end else begin
                clr_valid = 1'b1;
              end
            end
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (!res_v_r || out_ready) begin
          res_nxt = '{result_ident: 32'd0, status: ST_TICK_DONE, last: 1'b1};
          res_v_nxt = 1'b1;
          ptr_nxt = (ptr_r == SW'(SLOTS - 1)) ? '0 : ptr_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RES: begin
        if (!res_v_r || out_ready) begin
          res_v_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    ticks_r <= ticks_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (wr_en) begin
      slot_mem[ix] <= arm_slot;
      rnd_mem[ix] <= arm_rnd;
      tk_mem[ix] <= arm_ticks;
    end
    if (set_valid) begin
      id_mem[ix] <= item_r.ident;
      per_r[ix] <= item_r.periodic;
    end
    if (rnd_dec) begin
      rnd_mem[ix] <= rnd_mem[ix] - 1'b1;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      period_r <= TICK_PERIOD_RST;
      ptr_r <= '0;
      res_v_r <= 1'b0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r <= ptr_nxt;
      res_v_r <= res_v_nxt;
      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_data;
      end
      if (set_valid) begin
        valid_r[ix] <= 1'b1;
      end
      if (clr_valid) begin
        valid_r[ix] <= 1'b0;
      end
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_ptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_r != $past(ptr_r)) |-> ($past(state_r) == S_DONE))
    else $error("pointer moved outside tick");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_TICK_DONE) |-> out_data.last)
    else $error("tick done without last");
  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !dbusy) else $error("divider running while idle");

endmodule
